>>> hdl/kct_pkg.sv
// kct_pkg: shared constants, codes and types of the keyed counter table
// used by every module of the block and by its checker
// no dependencies
package kct_pkg;

  // table geometry
  localparam int ENTRIES    = 32;
  localparam int TAG_BITS   = 16;
  localparam int COUNT_BITS = 31;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  // field widths on the streams
  localparam int KIND_W  = 2;
  localparam int TAG_W   = 16;
  localparam int AMT_W   = 31;
  localparam int EV_W    = 3;
  localparam int IN_PAY_W     = TAG_W + AMT_W;
  localparam int IN_TDATA_W   = ((IN_PAY_W + 7) / 8) * 8;
  localparam int RES_W        = EV_W + 1 + 2 * AMT_W;
  localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVERRIDE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_ADDED   = 3'd1;
  localparam logic [EV_W-1:0] EV_CHANGED = 3'd2;
  localparam logic [EV_W-1:0] EV_REMOVED = 3'd3;
  localparam logic [EV_W-1:0] EV_INVALID = 3'd4;
  localparam logic [EV_W-1:0] EV_FULL    = 3'd5;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // ram access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // result, last field in the lowest bits
  typedef struct packed {
    logic [AMT_W-1:0] new_count;
    logic [AMT_W-1:0] old_count;
    logic             found;
    logic [EV_W-1:0]  event_res;
  } result_t;

endpackage

>>> hdl/kct_mem.sv
// kct_mem: tag/count storage, one write and one registered read per cycle
// depends on kct_pkg
module kct_mem
  import kct_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kct_ctrl.sv
// kct_ctrl: request sequencer, valid bits, table scan and read-modify-write
// depends on kct_pkg, drives kct_mem
module kct_ctrl
  import kct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [KIND_W-1:0] req_kind_i,
  input  logic [TAG_W-1:0]  req_tag_i,
  input  logic [AMT_W-1:0]  req_amount_i,
  output mem_req_t          mem_req_o,
  input  entry_t            mem_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [KIND_W-1:0]     kind_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [COUNT_BITS-1:0] amt_q;
  logic                  inv_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  hit_q, free_q;
  logic [IDX_W-1:0]      hit_idx_q, free_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [ENTRIES-1:0]    valid_q;

  logic                  accept;
  logic [TAG_BITS-1:0]   in_tag;
  logic [COUNT_BITS-1:0] in_amt;
  logic                  in_inv;
  logic                  issue;
  logic                  scan_done;

  // decision outputs
  result_t               res;
  logic                  wr_en, set_v, clr_v;
  logic [IDX_W-1:0]      wr_idx;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat;
  logic                  commit;

  // request intake: mask tag, clip amount
  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign in_tag      = req_tag_i[TAG_BITS-1:0];
  assign in_amt      = (req_amount_i > AMT_W'(COUNT_MAX)) ? COUNT_MAX
                                                          : req_amount_i[COUNT_BITS-1:0];
  assign in_inv      = (in_tag == '0) ||
                       (((req_kind_i == KIND_ADD) || (req_kind_i == KIND_REMOVE)) &&
                        (in_amt == '0));

  // scan issues one read per cycle
  assign issue     = (state_q == ST_SCAN) && (cnt_q < CNT_W'(ENTRIES));
  assign scan_done = (state_q == ST_SCAN) && !issue && !rd_vld_q;
  assign commit    = (state_q == ST_DECIDE) && res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = in_inv ? ST_DECIDE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outcome of the request from the scan results
  always_comb begin
    res    = '0;
    wr_en  = 1'b0;
    set_v  = 1'b0;
    clr_v  = 1'b0;
    wr_idx = hit_idx_q;
    wr_cnt = amt_q;
    sum    = {1'b0, hit_cnt_q} + {1'b0, amt_q};
    sat    = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
    if (inv_q) begin
      res.event_res = EV_INVALID;
    end else if (!hit_q) begin
      if (((kind_q == KIND_ADD) || (kind_q == KIND_OVERRIDE)) && (amt_q != '0)) begin
        if (!free_q) begin
          res.event_res = EV_FULL;
        end else begin
          res.event_res = EV_ADDED;
          res.new_count = AMT_W'(amt_q);
          wr_en         = 1'b1;
          set_v         = 1'b1;
          wr_idx        = free_idx_q;
        end
      end else begin
        res.event_res = EV_NONE;
      end
    end else begin
      res.found     = 1'b1;
      res.old_count = AMT_W'(hit_cnt_q);
      res.new_count = AMT_W'(hit_cnt_q);
      res.event_res = EV_NONE;
      case (kind_q)
        KIND_ADD: begin
          if (sat != hit_cnt_q) begin
            res.event_res = EV_CHANGED;
            res.new_count = AMT_W'(sat);
            wr_en         = 1'b1;
            wr_cnt        = sat;
          end
        end
        KIND_REMOVE: begin
          if (amt_q >= hit_cnt_q) begin
            res.event_res = EV_REMOVED;
            res.new_count = '0;
            clr_v         = 1'b1;
          end else begin
            res.event_res = EV_CHANGED;
            res.new_count = AMT_W'(hit_cnt_q - amt_q);
            wr_en         = 1'b1;
            wr_cnt        = hit_cnt_q - amt_q;
          end
        end
        KIND_OVERRIDE: begin
          if (amt_q == hit_cnt_q) begin
            res.event_res = EV_NONE;
          end else if (amt_q == '0) begin
            res.event_res = EV_REMOVED;
            res.new_count = '0;
            clr_v         = 1'b1;
          end else begin
            res.event_res = EV_CHANGED;
            res.new_count = AMT_W'(amt_q);
            wr_en         = 1'b1;
          end
        end
        default: begin
          res.event_res = EV_NONE;
        end
      endcase
    end
  end

  // ram access
  always_comb begin
    mem_req_o             = '0;
    mem_req_o.re          = issue;
    mem_req_o.raddr       = cnt_q[IDX_W-1:0];
    mem_req_o.we          = wr_en && commit;
    mem_req_o.waddr       = wr_idx;
    mem_req_o.wdata.tag   = tag_q;
    mem_req_o.wdata.count = wr_cnt;
  end

  assign res_valid_o = (state_q == ST_DECIDE);
  assign res_o       = res;

  // control state and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (accept) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // compare the entry read last cycle
      if (rd_vld_q) begin
        if (valid_q[rd_idx_q]) begin
          if (!hit_q && (mem_rdata_i.tag == tag_q)) hit_q <= 1'b1;
        end else if (!free_q) begin
          free_q <= 1'b1;
        end
      end
      if (commit && set_v) valid_q[wr_idx] <= 1'b1;
      if (commit && clr_v) valid_q[wr_idx] <= 1'b0;
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_kind_i;
      tag_q  <= in_tag;
      amt_q  <= in_amt;
      inv_q  <= in_inv;
    end
    rd_idx_q <= cnt_q[IDX_W-1:0];
    if (rd_vld_q) begin
      if (valid_q[rd_idx_q]) begin
        if (!hit_q && (mem_rdata_i.tag == tag_q)) begin
          hit_idx_q <= rd_idx_q;
          hit_cnt_q <= mem_rdata_i.count;
        end
      end else if (!free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
  end

endmodule

>>> hdl/kct_outreg.sv
// kct_outreg: output register of the result stream
// depends on kct_pkg
module kct_outreg
  import kct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_valid_i,
  output logic                   load_ready_o,
  input  result_t                load_data_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    valid_q;
  result_t data_q;

  // free when empty or being drained this cycle
  assign load_ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      data_q <= load_data_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(data_q);

endmodule

>>> hdl/keyed_counter_table.sv
// keyed_counter_table: top level of the keyed counter table
// depends on kct_pkg, kct_mem, kct_ctrl, kct_outreg
//
//   channel   direction  tdata (low bit up)                                      tuser
//   s_axis    in         tag[15:0], amount[46:16], zero pad                      kind[1:0]
//   m_axis    out        event_res[2:0], found[3], old[34:4], new[65:35], pad    -
//
// a request is accepted, then the tag/count ram is read one entry per cycle,
// then come a trailing compare, a step to close the scan and a step to decide
// and write back; a rejected request (tag 0, or zero amount on add or remove)
// goes from accept straight to decide.
// reset clears the valid bits at once, so the table is empty right after reset.
// the output register lets the next request in while a result waits; a second
// result holds the sequencer in its decide step until the register frees up.
module keyed_counter_table
  import kct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // tag, amount, zero pad
  input  logic [KIND_W-1:0]      s_axis_tuser,  // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // event_res, found, old_count, new_count, pad
);

  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     res_valid, res_ready;
  result_t  res;

  kct_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  kct_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_kind_i   (s_axis_tuser),
    .req_tag_i    (s_axis_tdata[TAG_W-1:0]),
    .req_amount_i (s_axis_tdata[IN_PAY_W-1:TAG_W]),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  kct_outreg u_outreg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (res_valid),
    .load_ready_o  (res_ready),
    .load_data_i   (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> hdl/kct_checker.sv
// kct_checker: port-level checks of the keyed counter table, bound to the top
// depends on kct_pkg and keyed_counter_table
module kct_checker
  import kct_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  result_t r;
  assign r = result_t'(m_axis_tdata[RES_W-1:0]);

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // only defined event codes
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r.event_res <= EV_FULL))
    else $error("undefined event code");

  // rejected or full requests report nothing
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (r.event_res == EV_INVALID || r.event_res == EV_FULL) |->
      !r.found && (r.old_count == '0) && (r.new_count == '0))
    else $error("rejected result carries data");

  // an absent tag had no count
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !r.found |-> (r.old_count == '0))
    else $error("absent tag with nonzero old count");

  // a removal needs a present tag and leaves zero
  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (r.event_res == EV_REMOVED) |-> r.found && (r.new_count == '0))
    else $error("bad removal result");

endmodule

bind keyed_counter_table kct_checker u_kct_checker (.*);

>>> tb/keyed_counter_table_checker.sv
// keyed_counter_table_checker: watches both streams of the keyed counter table,
// keeps its own copy of the table, predicts each result and compares it
// depends on kct_pkg
module keyed_counter_table_checker
  import kct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // tag, amount, zero pad
  input  logic [KIND_W-1:0]      s_axis_tuser,  // kind
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // event_res, found, old_count, new_count, pad
  output int                     mismatch_count_o,
  output int                     outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the table
  logic                  slot_used  [ENTRIES];
  logic [TAG_BITS-1:0]   slot_tag   [ENTRIES];
  logic [COUNT_BITS-1:0] slot_count [ENTRIES];

  // results still owed by the block, oldest first
  result_t owed_results[$];

  // apply one request to the shadow table and return the result it gives
  // amount width equals the count width here, so no clipping is needed
  function automatic result_t update_table(input logic [KIND_W-1:0]     kind,
                                           input logic [TAG_BITS-1:0]   tag,
                                           input logic [COUNT_BITS-1:0] amt);
    result_t               res;
    int                    hit;
    int                    free_slot;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] held;
    res       = '0;
    hit       = -1;
    free_slot = -1;

    // tag 0, or a zero amount on add or remove, is turned away
    if (tag == '0 || ((kind == KIND_ADD || kind == KIND_REMOVE) && amt == '0)) begin
      res.event_res = EV_INVALID;
      return res;
    end

    // lowest matching slot and lowest free slot
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_tag[i] == tag) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end

    // tag not in the table
    if (hit < 0) begin
      if ((kind == KIND_ADD || kind == KIND_OVERRIDE) && amt != '0) begin
        if (free_slot < 0) begin
          res.event_res = EV_FULL;
        end else begin
          slot_used[free_slot]  = 1'b1;
          slot_tag[free_slot]   = tag;
          slot_count[free_slot] = amt;
          res.event_res = EV_ADDED;
          res.new_count = amt;
        end
      end else begin
        res.event_res = EV_NONE;
      end
      return res;
    end

    held          = slot_count[hit];
    res.found     = 1'b1;
    res.old_count = held;
    res.new_count = held;
    res.event_res = EV_NONE;
    case (kind)
      KIND_ADD: begin
        // saturating add
        sum = {1'b0, held} + {1'b0, amt};
        if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
        if (sum[COUNT_BITS-1:0] != held) begin
          slot_count[hit] = sum[COUNT_BITS-1:0];
          res.event_res   = EV_CHANGED;
          res.new_count   = sum[COUNT_BITS-1:0];
        end
      end
      KIND_REMOVE: begin
        if (amt >= held) begin
          slot_used[hit] = 1'b0;
          res.event_res  = EV_REMOVED;
          res.new_count  = '0;
        end else begin
          slot_count[hit] = held - amt;
          res.event_res   = EV_CHANGED;
          res.new_count   = held - amt;
        end
      end
      KIND_OVERRIDE: begin
        if (amt == held) begin
          res.event_res = EV_NONE;
        end else if (amt == '0) begin
          slot_used[hit] = 1'b0;
          res.event_res  = EV_REMOVED;
          res.new_count  = '0;
        end else begin
          slot_count[hit] = amt;
          res.event_res   = EV_CHANGED;
          res.new_count   = amt;
        end
      end
      default: begin
        // query leaves the table alone
      end
    endcase
    return res;
  endfunction

  // count a bad result, print only the first few
  // values shown as event/found/old/new
  task automatic log_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t ns: %s: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
               $time, what, want.event_res, want.found, want.old_count, want.new_count,
               got.event_res, got.found, got.old_count, got.new_count);
    end
  endtask

  // predict on each input transaction, compare on each output transaction
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      owed_results.delete();
      outstanding_o    = 0;
      mismatch_count_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        owed_results.push_back(update_table(s_axis_tuser, s_axis_tdata[TAG_BITS-1:0],
                                            s_axis_tdata[TAG_W +: AMT_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[RES_W-1:0];
        if (owed_results.size() == 0) begin
          log_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = owed_results.pop_front();
          if (got.event_res !== want.event_res || got.found !== want.found ||
              got.old_count !== want.old_count || got.new_count !== want.new_count) begin
            log_mismatch("result mismatch", want, got);
          end
        end
      end
      outstanding_o = owed_results.size();
    end
  end

endmodule

>>> tb/keyed_counter_table_tb.sv
// keyed_counter_table_tb: drives requests into the keyed counter table, stalls
// the result stream and gives the verdict from the checker's mismatch and outstanding counts
// depends on kct_pkg, keyed_counter_table, keyed_counter_table_checker
module keyed_counter_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kct_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int POOL_SIZE     = 48;
  localparam int SETTLE_CYCLES = 40;

  // traffic shape of one stretch of random requests
  typedef enum int {PH_NARROW, PH_FILL, PH_WIDE, PH_DRAIN} phase_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // tag, amount, zero pad
  logic [KIND_W-1:0]      s_axis_tuser  = '0;  // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // event_res, found, old_count, new_count, pad
  int                     mismatch_count;
  int                     outstanding;

  int cycle_count = 0;
  int stall_left  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b0;

  // tags the random traffic works on, so the table can fill and drain
  logic [TAG_W-1:0] tag_pool [POOL_SIZE];

  keyed_counter_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  keyed_counter_table_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // result stream backpressure: none, short stalls or long stalls by turns
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      case ((cycle_count / 2500) % 3)
        1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 6);
        2: if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(20, 80);
        default: ;
      endcase
    end
  end

  // one input transaction, preceded, when gaps are on, by an idle gap at the end of a burst
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
                              input logic [AMT_W-1:0] amt);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_PAY_W){1'b0}}, amt, tag};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
  endtask

  // a stretch of random requests of one traffic shape
  task automatic run_phase(input phase_e mode, input int n_items);
    int               base;
    int               width;
    int               pick;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0] tag;
    logic [AMT_W-1:0] amt;
    if (mode == PH_NARROW) begin
      width = $urandom_range(2, 6);
      base  = $urandom_range(0, POOL_SIZE - width);
    end else begin
      width = POOL_SIZE;
      base  = 0;
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int n = 0; n < n_items; n++) begin
      // amount: mostly small so counts move up and down, some near saturation
      pick = $urandom_range(0, 99);
      if (pick < 4)       amt = '0;
      else if (pick < 45) amt = AMT_W'($urandom_range(1, 8));
      else if (pick < 60) amt = AMT_W'($urandom_range(1, 1000));
      else if (pick < 72) amt = COUNT_MAX - AMT_W'($urandom_range(0, 3));
      else                amt = AMT_W'($urandom);

      // kind mix depends on whether the table should fill or drain
      pick = $urandom_range(0, 99);
      case (mode)
        PH_FILL:  kind = (pick < 55) ? KIND_ADD : (pick < 65) ? KIND_REMOVE :
                         (pick < 85) ? KIND_OVERRIDE : KIND_QUERY;
        PH_DRAIN: kind = (pick < 10) ? KIND_ADD : (pick < 65) ? KIND_REMOVE :
                         (pick < 85) ? KIND_OVERRIDE : KIND_QUERY;
        default:  kind = (pick < 30) ? KIND_ADD : (pick < 55) ? KIND_REMOVE :
                         (pick < 80) ? KIND_OVERRIDE : KIND_QUERY;
      endcase
      if (mode == PH_DRAIN && kind != KIND_ADD && $urandom_range(0, 1) == 0) begin
        amt = (kind == KIND_REMOVE) ? COUNT_MAX : '0;
      end

      // tag: pool member, invalid, or a stray one that must not take a slot
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        tag = '0;
      end else if (pick < 9) begin
        tag = TAG_W'($urandom);
        if (kind == KIND_ADD) kind = KIND_QUERY;
        if (kind == KIND_OVERRIDE) amt = '0;
      end else begin
        tag = tag_pool[base + $urandom_range(0, width - 1)];
      end
      send_request(kind, tag, amt);
    end
  endtask

  // run ends here if the block hangs
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int  issued;
    int  n;
    int  k;
    bit  dup;
    // distinct nonzero pool tags
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        tag_pool[i] = TAG_W'($urandom_range(1, 65535));
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (tag_pool[j] == tag_pool[i]) dup = 1'b1;
      end while (dup);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // rejected requests and operations on an absent tag
    send_request(KIND_QUERY,    16'h0000, 31'd0);
    send_request(KIND_ADD,      16'h0000, 31'd5);
    send_request(KIND_REMOVE,   16'h0001, 31'd0);
    send_request(KIND_ADD,      16'h0001, 31'd0);
    send_request(KIND_OVERRIDE, 16'h0000, 31'd0);
    send_request(KIND_QUERY,    16'h0001, 31'd9);
    send_request(KIND_REMOVE,   16'h0001, 31'd3);
    send_request(KIND_OVERRIDE, 16'h0001, 31'd0);
    // new entry, saturation, override with held count, partial and full remove
    send_request(KIND_ADD,      16'h0001, 31'd1);
    send_request(KIND_ADD,      16'h0001, COUNT_MAX);
    send_request(KIND_ADD,      16'h0001, 31'd1);
    send_request(KIND_OVERRIDE, 16'h0001, COUNT_MAX);
    send_request(KIND_REMOVE,   16'h0001, 31'd5);
    send_request(KIND_QUERY,    16'h0001, 31'd0);
    send_request(KIND_REMOVE,   16'h0001, COUNT_MAX);
    // override creating an entry, changing it, exact remove
    send_request(KIND_OVERRIDE, 16'hFFFF, COUNT_MAX);
    send_request(KIND_OVERRIDE, 16'hFFFF, 31'd7);
    send_request(KIND_REMOVE,   16'hFFFF, 31'd7);
    send_request(KIND_QUERY,    16'hFFFF, COUNT_MAX);
    // override of a present tag with zero drops it; add and query of another tag, remove of an absent one
    send_request(KIND_ADD,      16'h8000, 31'd2);
    send_request(KIND_OVERRIDE, 16'h8000, 31'd0);
    send_request(KIND_ADD,      16'h5555, 31'h2AAAAAAA);
    send_request(KIND_QUERY,    16'h5555, 31'h55555555);
    send_request(KIND_REMOVE,   16'hAAAA, 31'd1);

    // random stretches: narrow mix, fill to full, wide mix, drain
    issued = 0;
    k      = 0;
    while (issued < RANDOM_ITEMS) begin
      n = $urandom_range(60, 140);
      run_phase(phase_e'(k % 4), n);
      issued += n;
      k++;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/kct_pkg.sv
hdl/kct_mem.sv
hdl/kct_ctrl.sv
hdl/kct_outreg.sv
hdl/keyed_counter_table.sv
hdl/kct_checker.sv
tb/keyed_counter_table_checker.sv
tb/keyed_counter_table_tb.sv
